>>> hdl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared widths, constants and types for the fractional clock divider search.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int FREQ_W      = 18;
    localparam int CLK_W       = 28;
    localparam int PCLK_W      = CLK_W - 1;
    localparam int FRAME_SHIFT = 23;                 // 2 * 32 bits * 2 = 128, then << 16
    localparam int NUM_W       = FREQ_W + FRAME_SHIFT;
    localparam int RATIO_W     = 24;                 // ratio bits that reach X and the error
    localparam int FRAC_W      = 16;
    localparam int DEN_W       = 8;
    localparam int CNT_W       = $clog2(NUM_W + 1);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [DEN_W-1:0]   MAX_DEN     = 8'd255;
    localparam logic [FRAC_W-1:0]  FRAC_HALF   = 16'h8000;
    localparam logic [FRAC_W-1:0]  ERR_INIT    = 16'hFFFF;
    localparam logic [RATIO_W-1:0] ROUND_ADD   = 24'h008000;
    localparam logic [CLK_W-1:0]   CLK_RESET   = 28'd100000000;
    localparam logic [PCLK_W-1:0]  PCLK_MIN    = 27'd1;
    localparam logic [CNT_W-1:0]   DIV_STEPS   = CNT_W'(NUM_W);

    // register index = paddr[2]
    localparam logic REG_CPU_CLOCK = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_SRCH = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    num;
        logic [PCLK_W-1:0]   den;
    } t_div_req;

endpackage

>>> hdl/fcd_div.sv
// ----------------------------------------------------------------------------
// fcd_div
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module fcd_div import fcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [RATIO_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [PCLK_W-1:0]    r_den, n_den;
    logic [PCLK_W-1:0]    r_rem, n_rem;
    logic [RATIO_W-1:0]   r_quot, n_quot;
    logic [PCLK_W:0]      trial;
    logic [PCLK_W:0]      diff;
    logic                 qbit;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_STEPS;
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_quot = '0;
        end else if (r_busy) begin
            n_num  = {r_num[NUM_W-2:0], 1'b0};
            n_rem  = qbit ? diff[PCLK_W-1:0] : trial[PCLK_W-1:0];
            n_quot = {r_quot[RATIO_W-2:0], qbit};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hdl/fractional_clock_divider_search.sv
// ----------------------------------------------------------------------------
// fractional_clock_divider_search
// Finds the 8-bit X/Y fractional divider pair for a requested sample rate.
// ----------------------------------------------------------------------------
// A request runs through the serial divider, which forms the 8.16 ratio
// (sample_freq << 23) / (cpu_clock_hz / 2); PREP then forms 255 * ratio,
// SRCH tries one Y per cycle from 255 down to 1 on a single shared
// subtractor (stopping early when an exact Y turns up), and DONE forms X.
// Input is taken only while the search is idle; the result sits in an
// output register until its transfer completes.
module fractional_clock_divider_search import fcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // request
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FREQ_W-1:0]   i_sample_freq,
    // result
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DEN_W-1:0]    o_div_y,
    output logic [DEN_W-1:0]    o_div_x,
    output logic [2*DEN_W-1:0]  o_rate_word,
    output logic [FRAC_W-1:0]   o_best_error
);

    t_state               r_state, n_state;
    logic [CLK_W-1:0]     r_cpu_clk;
    logic [RATIO_W-1:0]   r_ratio, n_ratio;
    logic [RATIO_W-1:0]   r_acc, n_acc;
    logic [RATIO_W-1:0]   r_best_prod, n_best_prod;
    logic [DEN_W-1:0]     r_y, n_y;
    logic [DEN_W-1:0]     r_best_y, n_best_y;
    logic [FRAC_W-1:0]    r_best_err, n_best_err;
    logic                 r_out_valid, n_out_valid;
    logic [DEN_W-1:0]     r_div_y, n_div_y;
    logic [DEN_W-1:0]     r_div_x, n_div_x;
    logic [FRAC_W-1:0]    r_err_out, n_err_out;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [PCLK_W-1:0]    pclk;
    t_div_req             div_req;
    logic                 div_done;
    logic [RATIO_W-1:0]   div_quot;
    logic [RATIO_W-1:0]   sub_a;
    logic [RATIO_W-1:0]   sub_res;
    logic [FRAC_W-1:0]    frac;
    logic [FRAC_W-1:0]    err;
    logic [RATIO_W-1:0]   rounded;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_CPU_CLOCK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_clk <= CLK_RESET;
        end else if (cfg_wr) begin
            r_cpu_clk <= pwdata[CLK_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_CPU_CLOCK)
                  ? {{(PDATA_W-CLK_W){1'b0}}, r_cpu_clk} : '0;

    // ---------------- ratio divider ----------------
    assign in_xfer = i_in_valid && o_in_ready;
    assign pclk    = (r_cpu_clk[CLK_W-1:1] == '0) ? PCLK_MIN : r_cpu_clk[CLK_W-1:1];

    assign div_req.start = in_xfer;
    assign div_req.num   = {i_sample_freq, {FRAME_SHIFT{1'b0}}};
    assign div_req.den   = pclk;

    fcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ---------------- shared subtractor ----------------
    // PREP: (ratio << 8) - ratio = 255 * ratio; SRCH: step the product down one Y
    assign sub_a   = r_state[2] ? {r_ratio[RATIO_W-DEN_W-1:0], {DEN_W{1'b0}}} : r_acc;
    assign sub_res = sub_a - r_ratio;

    assign frac    = r_acc[FRAC_W-1:0];
    assign err     = (frac > FRAC_HALF) ? FRAC_W'(~frac + 1'b1) : frac;
    assign rounded = r_best_prod + ROUND_ADD;

    always_comb begin
        n_state     = r_state;
        n_ratio     = r_ratio;
        n_acc       = r_acc;
        n_best_prod = r_best_prod;
        n_y         = r_y;
        n_best_y    = r_best_y;
        n_best_err  = r_best_err;
        n_out_valid = r_out_valid;
        n_div_y     = r_div_y;
        n_div_x     = r_div_x;
        n_err_out   = r_err_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_ratio = div_quot;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_acc      = sub_res;
                n_y        = MAX_DEN;
                n_best_err = ERR_INIT;
                n_state    = ST_SRCH;
            end
            ST_SRCH: begin
                if (err == '0) begin
                    n_best_prod = r_acc;
                    n_best_y    = r_y;
                    n_best_err  = '0;
                    n_state     = ST_DONE;
                end else begin
                    if (err < r_best_err) begin
                        n_best_prod = r_acc;
                        n_best_y    = r_y;
                        n_best_err  = err;
                    end
                    if (r_y == DEN_W'(1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_y   = r_y - 1'b1;
                        n_acc = sub_res;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_div_y     = r_best_y;
                    n_div_x     = rounded[RATIO_W-1:FRAC_W];
                    n_err_out   = r_best_err;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ratio     <= n_ratio;
        r_acc       <= n_acc;
        r_best_prod <= n_best_prod;
        r_y         <= n_y;
        r_best_y    <= n_best_y;
        r_best_err  <= n_best_err;
        r_div_y     <= n_div_y;
        r_div_x     <= n_div_x;
        r_err_out   <= n_err_out;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_div_y      = r_div_y;
    assign o_div_x      = r_div_x;
    assign o_rate_word  = {r_div_x, r_div_y};
    assign o_best_error = r_err_out;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fractional_clock_divider_search. Requests go in
// over a valid/ready channel, and an in-bench model of the X/Y search predicts
// each result. Results are checked field by field in order. The CPU clock
// register is written and read back over APB, but only while the block is
// idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb import fcd_pkg::*; ;

    localparam int unsigned AUDIO_RATES [8] = '{8000, 11025, 16000, 22050,
                                                32000, 44100, 48000, 96000};
    localparam int unsigned TYPICAL_CLOCKS [6] = '{12000000, 24000000, 48000000,
                                                   72000000, 96000000, 120000000};

    typedef struct {
        logic [DEN_W-1:0]   div_y;
        logic [DEN_W-1:0]   div_x;
        logic [2*DEN_W-1:0] rate_word;
        logic [FRAC_W-1:0]  best_error;
    } divider_result_t;

    class divider_scoreboard;
        divider_result_t pending_divisors[$];
        int unsigned     mismatches = 0;

        // Search Y from the top for the smallest distance of Y*ratio to an integer.
        function void note_request(logic [FREQ_W-1:0] freq, logic [CLK_W-1:0] cpu_clk);
            bit [63:0]       pclk;
            bit [63:0]       ratio;
            bit [63:0]       prod;
            bit [16:0]       frac;
            bit [16:0]       err;
            bit [16:0]       best_err;
            bit [DEN_W-1:0]  best_y;
            bit              exact;
            divider_result_t r;
            pclk = 64'(cpu_clk >> 1);
            if (pclk == 0) begin
                pclk = 1;
            end
            // 2 * freq * 32 bits * 2 channels, in 48.16
            ratio = ((64'(freq) * 64'd128) << 16) / pclk;
            best_err = 17'(ERR_INIT);
            best_y   = '0;
            exact    = 1'b0;
            for (int y = MAX_DEN; y > 0 && !exact; y--) begin
                prod = 64'(y) * ratio;
                frac = 17'(prod[15:0]);
                err  = (frac > 17'(FRAC_HALF)) ? 17'h10000 - frac : frac;
                if (err == 0) begin
                    best_y = DEN_W'(y);
                    exact  = 1'b1;
                end else if (err < best_err) begin
                    best_err = err;
                    best_y   = DEN_W'(y);
                end
            end
            if (exact) begin
                best_err = '0;
            end
            prod = 64'(best_y) * ratio + 64'h8000;
            r.div_y      = best_y;
            r.div_x      = prod[23:16];
            r.rate_word  = {prod[23:16], best_y};
            r.best_error = best_err[FRAC_W-1:0];
            pending_divisors.push_back(r);
        endfunction

        function void check_result(logic [DEN_W-1:0] y, logic [DEN_W-1:0] x,
                                   logic [2*DEN_W-1:0] rate, logic [FRAC_W-1:0] err);
            divider_result_t e;
            if (pending_divisors.size() == 0) begin
                $error("result transfer with no request pending");
                mismatches++;
                return;
            end
            e = pending_divisors.pop_front();
            if (y !== e.div_y) begin
                $error("div_y: expected %0d, got %0d", e.div_y, y);
                mismatches++;
            end
            if (x !== e.div_x) begin
                $error("div_x: expected %0d, got %0d", e.div_x, x);
                mismatches++;
            end
            if (rate !== e.rate_word) begin
                $error("rate_word: expected 0x%04h, got 0x%04h", e.rate_word, rate);
                mismatches++;
            end
            if (err !== e.best_error) begin
                $error("best_error: expected 0x%04h, got 0x%04h", e.best_error, err);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [FREQ_W-1:0]   i_sample_freq;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DEN_W-1:0]    o_div_y;
    logic [DEN_W-1:0]    o_div_x;
    logic [2*DEN_W-1:0]  o_rate_word;
    logic [FRAC_W-1:0]   o_best_error;

    divider_scoreboard   sb = new();
    logic [CLK_W-1:0]    cpu_clock_shadow = CLK_RESET;
    logic                calm = 1'b0;       // no idling on either side

    fractional_clock_divider_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_freq (i_sample_freq),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_div_y       (o_div_y),
        .o_div_x       (o_div_x),
        .o_rate_word   (o_rate_word),
        .o_best_error  (o_best_error)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // result side: check each transfer, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_div_y, o_div_x, o_rate_word, o_best_error);
        end
        i_out_ready <= calm || ($urandom_range(99) >= 8);
    end

    task automatic send_request(input logic [FREQ_W-1:0] freq);
        while (!calm && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample_freq <= freq;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(freq, cpu_clock_shadow);
    endtask

    task automatic wait_for_results;
        i_in_valid <= 1'b0;
        while (sb.pending_divisors.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Block must be idle: drain first, then write and read back over APB.
    task automatic program_cpu_clock(input logic [CLK_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        wait_for_results();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CPU_CLOCK, 2'b00};
        pwdata  <= {4'($urandom), value};     // upper bits must be ignored
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cpu_clock_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(value)) begin
            $error("cpu_clock_hz: expected %0d, got %0d", value, readback);
            sb.mismatches++;
        end
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            4:       return FREQ_W'($urandom);
            5:       return FREQ_W'(AUDIO_RATES[$urandom_range(7)]);
            6:       return FREQ_W'($urandom_range(300, 0));
            7:       return FREQ_W'($urandom_range(200000, 190000));
            default: return FREQ_W'($urandom_range(200000, 0));
        endcase
    endfunction

    function automatic logic [CLK_W-1:0] pick_cpu_clock();
        case ($urandom_range(5))
            0:       return CLK_W'($urandom_range(200000000, 2));
            1:       return CLK_W'($urandom);
            2:       return CLK_W'($urandom_range(4000, 0));
            // pclk a multiple of 256 * rate gives short exact ratios
            3:       return CLK_W'(512 * AUDIO_RATES[$urandom_range(7)] * $urandom_range(8, 1));
            4:       return CLK_W'(TYPICAL_CLOCKS[$urandom_range(5)]);
            default: return $urandom_range(1) ? CLK_W'(200000000) : CLK_W'(2);
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_sample_freq <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset clock, field extremes and common rates
        send_request('0);
        send_request(18'd1);
        send_request(18'd8000);
        send_request(18'd44100);
        send_request(18'd48000);
        send_request(18'd96000);
        send_request(18'd200000);
        send_request(18'h3FFFF);
        send_request(18'h15555);
        send_request(18'h2AAAA);
        // ratio of exactly one half: odd Y lands on a half
        program_cpu_clock(28'd51200);
        send_request(18'd100);
        send_request(18'd50);
        send_request(18'd200000);
        // zero peripheral clock taken as one; X wraps
        program_cpu_clock(28'd0);
        send_request(18'd1);
        send_request(18'd200000);
        program_cpu_clock(28'd1);
        send_request(18'd3);
        program_cpu_clock(28'hFFFFFFF);
        send_request(18'd200000);
        send_request(18'd1);
        program_cpu_clock(28'd200000000);
        send_request(18'd44100);
        program_cpu_clock(28'd2);
        send_request(18'd48000);

        for (int phase = 0; phase < 7; phase++) begin
            program_cpu_clock(pick_cpu_clock());
            calm = (phase == 3);
            for (int n = 0; n < 100; n++) begin
                if (phase == 5 && n == 50) begin
                    wait_for_results();
                end
                send_request(pick_freq());
            end
        end
        calm = 1'b0;

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
hdl/fcd_pkg.sv
hdl/fcd_div.sv
hdl/fractional_clock_divider_search.sv
bench/tb.sv
